/* src/stwk_pkg.sv */
package stwk_pkg;

  // Command codes carried in the op field.
  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  // Status codes reported with every result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] value;
    logic [4:0]  position;
  } in_t;

  typedef struct packed {
    logic [4:0]  count;
    logic [63:0] read_word;
    logic [4:0]  removed;
    logic [1:0]  status;
  } out_t;

  // Where a cell takes its next word from.
  typedef enum logic [2:0] {
    CS_HOLD,
    CS_NEW,
    CS_UP,
    CS_DOWN,
    CS_WRAP
  } cell_sel_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

endpackage

/* src/stack_with_key_delete_and_insert_core.sv */
// Latency: push, insert, clear, rejected commands and unused op codes return their result
//   in the cycle after the beat is accepted; a new beat may be accepted in that same cycle.
// Delete and a valid read rotate the cell chain once per entry held; the result appears
//   in the cycle after the last rotation, and no new beat is accepted until then.
// Reset (synchronous, active low) empties the stack; the cells themselves are not cleared.
// The result strobe lasts one cycle and the receiver cannot stall it.
module stack_with_key_delete_and_insert_core #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  stwk_pkg::in_t  in_data,
  output logic           out_valid,
  output stwk_pkg::out_t out_data
);

  // Fill needs to hold DEPTH itself; CW is wide enough to compare fill with a position.
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = (FW > 5) ? FW : 5;

  stwk_pkg::state_t state_r, state_nxt;

  logic [FW-1:0]        fill_r, fill_nxt;
  logic [FW-1:0]        s_r, s_nxt;
  logic [FW-1:0]        tail_r, tail_nxt;
  logic [WORD_BITS-1:0] key_r, key_nxt;
  logic [4:0]           pos_r, pos_nxt;
  logic                 rd_mode_r, rd_mode_nxt;
  logic [WORD_BITS-1:0] rd_r, rd_nxt;
  logic                 out_valid_r, out_valid_nxt;
  stwk_pkg::out_t       out_r, out_nxt;

  stwk_pkg::cell_sel_t  cell_sel [DEPTH];
  logic [WORD_BITS-1:0] words [DEPTH];

  logic                 ins_en;
  logic [CW-1:0]        ins_pos;
  logic                 scan_en;
  logic                 keep;
  logic                 last_step;
  logic                 go_scan;
  logic [WORD_BITS-1:0] w_in;
  logic [WORD_BITS-1:0] head;
  logic [CW-1:0]        pos_c;
  logic [CW-1:0]        fill_c;

  // Counts are reported in the five-bit result fields.
  function automatic logic [4:0] cnt5(input logic [FW-1:0] v);
    logic [CW-1:0] e;
    e = CW'(v);
    return e[4:0];
  endfunction

  assign w_in   = in_data.value[WORD_BITS-1:0];
  assign pos_c  = CW'(in_data.position);
  assign fill_c = CW'(fill_r);
  assign head   = words[0];

  // The top cell is the one under inspection during a rotation. A read keeps every
  // word, so the chain comes back to its original order after fill rotations.
  assign keep      = rd_mode_r || (head != key_r);
  assign last_step = (s_r == (fill_r - FW'(1)));

  // Delete on a non-empty stack and an in-range read need a pass over the chain.
  assign go_scan = ((in_data.op == stwk_pkg::OP_DELETE) && (fill_r != '0)) ||
                   ((in_data.op == stwk_pkg::OP_READ) && (pos_c < fill_c));

  // The chain of cells. During insert, cells deeper than the position take their
  // upper neighbor and the cell at the position takes the new word. During a pass,
  // every cell but the deepest takes its lower neighbor, and the cell at the tail of the kept run
  // takes the top word when that word survives.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] up_word;
    logic [WORD_BITS-1:0] down_word;

    always_comb begin
      cell_sel[i] = stwk_pkg::CS_HOLD;
      if (ins_en) begin
        if (CW'(i) > ins_pos) begin
          cell_sel[i] = stwk_pkg::CS_UP;
        end else if (CW'(i) == ins_pos) begin
          cell_sel[i] = stwk_pkg::CS_NEW;
        end
      end else if (scan_en) begin
        if ((FW'(i) == tail_r) && keep) begin
          cell_sel[i] = stwk_pkg::CS_WRAP;
        end else if (i < DEPTH - 1) begin
          cell_sel[i] = stwk_pkg::CS_DOWN;
        end
      end
    end

    if (i == 0) begin : g_first
      assign up_word = w_in;
    end else begin : g_mid
      assign up_word = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign down_word = words[i];
    end else begin : g_inner
      assign down_word = words[i+1];
    end

    stwk_cell #(
      .WORD_BITS(WORD_BITS)
    ) u_cell (
      .clk       (clk),
      .sel       (cell_sel[i]),
      .new_word  (w_in),
      .up_word   (up_word),
      .down_word (down_word),
      .wrap_word (head),
      .word      (words[i])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stwk_pkg::S_IDLE: begin
        if (start && go_scan) begin
          state_nxt = stwk_pkg::S_SCAN;
        end
      end
      stwk_pkg::S_SCAN: begin
        if (last_step) begin
          state_nxt = stwk_pkg::S_IDLE;
        end
      end
      default: state_nxt = stwk_pkg::S_IDLE;
    endcase
  end

  // Datapath control and result formation.
  always_comb begin
    logic [FW-1:0] new_fill;

    new_fill      = fill_r;
    fill_nxt      = fill_r;
    s_nxt         = s_r;
    tail_nxt      = tail_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    rd_mode_nxt   = rd_mode_r;
    rd_nxt        = rd_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ins_en        = 1'b0;
    ins_pos       = pos_c;
    scan_en       = 1'b0;

    case (state_r)
      stwk_pkg::S_IDLE: begin
        if (start) begin
          key_nxt       = w_in;
          pos_nxt       = in_data.position;
          rd_mode_nxt   = (in_data.op == stwk_pkg::OP_READ);
          rd_nxt        = '0;
          s_nxt         = '0;
          tail_nxt      = fill_r - FW'(1);
          out_valid_nxt = !go_scan;
          out_nxt.count     = cnt5(fill_r);
          out_nxt.read_word = '0;
          out_nxt.removed   = '0;
          out_nxt.status    = stwk_pkg::ST_OK;
          case (in_data.op)
            stwk_pkg::OP_PUSH: begin
              if (fill_r == FW'(DEPTH)) begin
                out_nxt.status = stwk_pkg::ST_FULL;
              end else begin
                ins_en        = 1'b1;
                ins_pos       = '0;
                fill_nxt      = fill_r + FW'(1);
                out_nxt.count = cnt5(fill_r + FW'(1));
              end
            end
            stwk_pkg::OP_INSERT: begin
              // Fullness is checked before the position.
              if (fill_r == FW'(DEPTH)) begin
                out_nxt.status = stwk_pkg::ST_FULL;
              end else if (pos_c > fill_c) begin
                out_nxt.status = stwk_pkg::ST_RANGE;
              end else begin
                ins_en        = 1'b1;
                fill_nxt      = fill_r + FW'(1);
                out_nxt.count = cnt5(fill_r + FW'(1));
              end
            end
            stwk_pkg::OP_CLEAR: begin
              fill_nxt        = '0;
              out_nxt.count   = '0;
              out_nxt.removed = cnt5(fill_r);
            end
            stwk_pkg::OP_READ: begin
              if (!go_scan) begin
                out_nxt.status = stwk_pkg::ST_RANGE;
              end
            end
            default: begin
              // Delete starts a pass, or on an empty stack reports nothing removed.
              // Unused codes only report the count.
            end
          endcase
        end
      end
      stwk_pkg::S_SCAN: begin
        scan_en = 1'b1;
        if (CW'(s_r) == CW'(pos_r)) begin
          rd_nxt = head;
        end
        // A dropped word shortens the kept run by one.
        tail_nxt = keep ? tail_r : (tail_r - FW'(1));
        s_nxt    = s_r + FW'(1);
        if (last_step) begin
          new_fill          = tail_nxt + FW'(1);
          fill_nxt          = new_fill;
          out_valid_nxt     = 1'b1;
          out_nxt.count     = cnt5(new_fill);
          out_nxt.read_word = rd_mode_r ? 64'(rd_nxt) : '0;
          out_nxt.removed   = rd_mode_r ? '0 : cnt5(fill_r - new_fill);
          out_nxt.status    = stwk_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stwk_pkg::S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r       <= s_nxt;
    tail_r    <= tail_nxt;
    key_r     <= key_nxt;
    pos_r     <= pos_nxt;
    rd_mode_r <= rd_mode_nxt;
    rd_r      <= rd_nxt;
    out_r     <= out_nxt;
  end

  assign busy      = (state_r != stwk_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  // Every accepted beat either yields its result next cycle or starts a pass.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted beat produced neither result nor pass");

  // The fill never exceeds the number of cells.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(DEPTH))
    else $error("fill above depth");

  // During a pass the tail of the kept run stays inside the held entries.
  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stwk_pkg::S_SCAN) |-> (tail_r < fill_r))
    else $error("kept run tail beyond fill");

  // A pass ends with exactly one result strobe.
  a_pass_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == stwk_pkg::S_SCAN) && last_step) |=> out_valid)
    else $error("pass finished without a result");
`endif

endmodule

/* src/stwk_cell.sv */
module stwk_cell #(
  parameter int WORD_BITS = 64
) (
  input  logic                  clk,
  input  stwk_pkg::cell_sel_t   sel,
  input  logic [WORD_BITS-1:0]  new_word,
  input  logic [WORD_BITS-1:0]  up_word,
  input  logic [WORD_BITS-1:0]  down_word,
  input  logic [WORD_BITS-1:0]  wrap_word,
  output logic [WORD_BITS-1:0]  word
);

  logic [WORD_BITS-1:0] word_r;

  // The held word is payload, so it has no reset.
  always_ff @(posedge clk) begin
    case (sel)
      stwk_pkg::CS_NEW:  word_r <= new_word;
      stwk_pkg::CS_UP:   word_r <= up_word;
      stwk_pkg::CS_DOWN: word_r <= down_word;
      stwk_pkg::CS_WRAP: word_r <= wrap_word;
      default:           word_r <= word_r;
    endcase
  end

  assign word = word_r;

endmodule
